// ===== rtl/core/demb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// demb_pkg
// Shared types and constants of the diagonal emboss filter.
// ----------------------------------------------------------------------------
package demb_pkg;

  localparam int DEF_MAX_LINE_PIXELS = 2048;
  localparam int WIDTH_REG_W   = 12;
  localparam int HEIGHT_REG_W  = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_INDEX_W   = 1;
  localparam int OUT_COL_W     = 11;
  localparam int OUT_ROW_W     = 12;
  // wide enough for any clamped width or height and their compares
  localparam int DIM_W         = 14;
  localparam int MIN_DIM       = 3;
  localparam int ROW_LIMIT     = 4096;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int EMBOSS_OFFSET = 100;
  localparam int CHANNEL_MAX   = 255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
  } pixel_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0] out_column;
    logic [OUT_ROW_W-1:0] out_row;
    logic [7:0]           emboss_blue;
    logic [7:0]           emboss_green;
    logic [7:0]           emboss_red;
    logic                 frame_last;
  } result_t;

  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/diagonal_emboss_filter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// diagonal_emboss_filter_top
// 3x3 diagonal emboss over a raster BGR pixel stream.
//
// Pixels enter on the pixel channel (valid/ready) in raster order. For a
// pixel at (x,y) with x,y >= 2 one result item leaves on the result channel
// with the embossed value of (x-1,y-1): upper-left minus lower-right plus
// 100, clamped to 0..255 per channel, plus its coordinates and a flag on
// the last interior pixel of the frame. Border pixels yield no item.
// The line memory read is issued at the accept edge together with stage 1,
// and the output register loads when stage 1 retires.
// Throughput is one pixel per cycle while the receiver does not stall, set
// by the line memory, which takes one read and one write each cycle (both
// line stores share one 48-bit word).
// Reset clears counters, pipeline valids and loads width 640, height 480;
// the line memory is not cleared; entries read before written feed no result.
// When the receiver stalls, a waiting result holds in the output register;
// one more pixel enters stage 1, and further pixels are held off only when
// that pixel would also produce a result.
// Configuration writes (cfg_write) take effect at the next pixel.
// ----------------------------------------------------------------------------
module diagonal_emboss_filter_top
  import demb_pkg::*;
#(
  parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   pixel_valid,
  output logic                        pixel_ready,
  input  wire pixel_t                 pixel,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output result_t                     result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;

  // configuration
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [DIM_W-1:0]        eff_width;
  logic [DIM_W-1:0]        eff_height;

  // position counters
  logic [COL_W-1:0]     col_count, col_next, col_cur;
  logic [OUT_ROW_W-1:0] row_count, row_next, row_cur;
  logic [DIM_W-1:0]     col_ext, col_inc, row_pre, row_inc;
  logic                 col_wrap, line_end, emit_cur, last_cur;

  // stage 1
  logic                 s1_valid, s1_emit, s1_last, s1_fire;
  logic [COL_W-1:0]     s1_col;
  logic [OUT_ROW_W-1:0] s1_row;
  pixel_t               s1_pix;
  pixel_t               diag0, diag1;
  logic                 pixel_fire;

  // line memory: older and newer line share one word
  line_entry_t line_mem [MAX_LINE_PIXELS];
  line_entry_t line_rd;

  function automatic logic [7:0] emboss(input logic [7:0] ul, input logic [7:0] lr);
    logic signed [9:0] v;
    v = $signed({2'b00, ul}) - $signed({2'b00, lr}) + 10'(EMBOSS_OFFSET);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 10'(CHANNEL_MAX)) begin
      return 8'(CHANNEL_MAX);
    end else begin
      return v[7:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(WIDTH_RESET);
      image_height <= HEIGHT_REG_W'(HEIGHT_RESET);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (DIM_W'(image_width) < DIM_W'(MIN_DIM)) begin
      eff_width = DIM_W'(MIN_DIM);
    end else if (DIM_W'(image_width) > DIM_W'(MAX_LINE_PIXELS)) begin
      eff_width = DIM_W'(MAX_LINE_PIXELS);
    end else begin
      eff_width = DIM_W'(image_width);
    end
    if (DIM_W'(image_height) < DIM_W'(MIN_DIM)) begin
      eff_height = DIM_W'(MIN_DIM);
    end else if (DIM_W'(image_height) > DIM_W'(ROW_LIMIT)) begin
      eff_height = DIM_W'(ROW_LIMIT);
    end else begin
      eff_height = DIM_W'(image_height);
    end
  end

  // position of the incoming pixel, with wrap after a width/height change
  always_comb begin
    col_ext  = DIM_W'(col_count);
    col_wrap = col_ext >= eff_width;
    row_pre  = col_wrap ? DIM_W'(row_count) + DIM_W'(1) : DIM_W'(row_count);
    row_cur  = (row_pre >= eff_height) ? '0 : row_pre[OUT_ROW_W-1:0];
    col_cur  = col_wrap ? '0 : col_count;

    emit_cur = (DIM_W'(col_cur) >= DIM_W'(2)) && (row_cur >= OUT_ROW_W'(2));
    last_cur = (DIM_W'(col_cur) == eff_width - DIM_W'(1))
            && (DIM_W'(row_cur) == eff_height - DIM_W'(1));

    col_inc  = DIM_W'(col_cur) + DIM_W'(1);
    row_inc  = DIM_W'(row_cur) + DIM_W'(1);
    line_end = col_inc >= eff_width;
    if (line_end) begin
      col_next = '0;
      row_next = (row_inc >= eff_height) ? '0 : row_inc[OUT_ROW_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row_cur;
    end
  end

  assign s1_fire     = s1_valid && (!s1_emit || !result_valid || result_ready);
  assign pixel_ready = !s1_valid || s1_fire;
  assign pixel_fire  = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (pixel_fire) begin
        col_count <= col_next;
        row_count <= row_next;
      end
      if (pixel_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      s1_col  <= col_cur;
      s1_row  <= row_cur;
      s1_pix  <= pixel;
      s1_emit <= emit_cur;
      s1_last <= last_cur;
    end
  end

  // read at accept, write back when stage 1 retires
  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      line_rd <= line_mem[col_cur];
    end
    if (s1_fire) begin
      line_mem[s1_col] <= '{older: line_rd.newer, newer: s1_pix};
    end
  end

  // line y-2 at columns x-1 and x-2
  always_ff @(posedge clk) begin
    if (rst) begin
      diag0 <= '0;
      diag1 <= '0;
    end else if (s1_fire) begin
      diag1 <= diag0;
      diag0 <= line_rd.older;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      result.out_column   <= OUT_COL_W'(s1_col - COL_W'(1));
      result.out_row      <= s1_row - OUT_ROW_W'(1);
      result.emboss_blue  <= emboss(diag1.pixel_blue, s1_pix.pixel_blue);
      result.emboss_green <= emboss(diag1.pixel_green, s1_pix.pixel_green);
      result.emboss_red   <= emboss(diag1.pixel_red, s1_pix.pixel_red);
      result.frame_last   <= s1_last;
    end
  end

`ifndef ASSERT_OFF
  // a stalled result-producing item in stage 1 blocks new pixels
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emit && result_valid && !result_ready |-> !pixel_ready)
    else $error("pixel taken while stage 1 is blocked");

  // results never come from column 0 or row 0
  a_interior: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.out_column != '0) && (result.out_row != '0))
    else $error("border pixel emitted");

  // a read never hits the entry being written back in the same cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    pixel_fire && s1_fire |-> col_cur != s1_col)
    else $error("line memory read and write collide");
`endif

endmodule
`default_nettype wire
